/* src/ssmt_pkg.sv */
// Package for the sparse set membership table.
// Holds the table size, field widths, operation and status codes and shared types.
// No dependencies.
package ssmt_pkg;

    localparam int KEYS    = 256;
    localparam int IDX_W   = $clog2(KEYS);
    localparam int MODE_W  = 2;
    localparam int KEY_W   = 9;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;
    localparam int SLOT_W  = 8;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLOT_W-1:0]  slot_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_ABSENT = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } state_t;

    // One write port of a table memory
    typedef struct packed {
        logic en;
        idx_t addr;
        idx_t data;
    } mem_wr_t;

endpackage

/* src/ssmt_slot_ram.sv */
// Key-to-slot memory: one read port, one write port, registered read.
// A read and a write to the same entry at the same edge return the new word.
// Depends on ssmt_pkg.
module ssmt_slot_ram (
    input  logic             clk,
    input  logic             ren,
    input  ssmt_pkg::idx_t   raddr,
    input  ssmt_pkg::mem_wr_t wr,
    output ssmt_pkg::idx_t   rdata
);
    import ssmt_pkg::*;

    idx_t mem [KEYS];
    idx_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Forward the word being written so a back-to-back item sees it
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            if (wr.en && (wr.addr == raddr))
            begin
                rdata_reg <= wr.data;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ssmt_dense_ram.sv */
// Packed member memory: two read ports, one write port, registered reads.
// Port a fetches the entry at the key's slot, port b the last member.
// Depends on ssmt_pkg.
module ssmt_dense_ram (
    input  logic              clk,
    input  logic              ren,
    input  ssmt_pkg::idx_t    raddr_a,
    input  ssmt_pkg::idx_t    raddr_b,
    input  ssmt_pkg::mem_wr_t wr,
    output ssmt_pkg::idx_t    rdata_a,
    output ssmt_pkg::idx_t    rdata_b
);
    import ssmt_pkg::*;

    idx_t mem [KEYS];
    idx_t rdata_a_reg;
    idx_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* src/sparse_set_membership_table.sv */
// Sparse set membership table over keys 0 to KEYS-1: query, add, remove and clear, one
// result word per input word. The key's slot is read from the key-to-slot memory at the
// accepting edge, the packed entry at that slot and the last member are read from the
// packed memory on the next edge, as that read depends on the first, and the update is
// written in the update state once the output is free, when the next word may already
// be accepted. Both memories need no clearing after reset.
// Depends on ssmt_pkg, ssmt_slot_ram and ssmt_dense_ram.
module sparse_set_membership_table (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              mode,
    input  logic [8:0]              key,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic                    present,
    output logic [8:0]              member_count,
    output logic [7:0]              slot
);
    import ssmt_pkg::*;

    state_t  state_reg, state_next;
    mode_t   mode_reg;
    key_t    key_reg;
    idx_t    s_reg;
    count_t  count_reg, count_next;

    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    logic    present_reg, present_next;
    count_t  mcount_reg, mcount_next;
    slot_t   slot_reg, slot_next;

    logic    in_fire;
    logic    out_free;
    logic    update_fire;
    idx_t    slot_rdata;
    idx_t    dense_s;
    idx_t    dense_last;
    idx_t    last_idx;
    idx_t    key_idx;
    logic    in_range;
    logic    is_mem;
    mem_wr_t slot_wr;
    mem_wr_t dense_wr;

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE) || ((state_reg == S_UPDATE) && out_free);
    assign in_fire     = in_valid && in_ready;
    assign update_fire = (state_reg == S_UPDATE) && out_free;

    assign key_idx  = key_reg[IDX_W-1:0];
    assign last_idx = IDX_W'(count_reg - count_t'(1));
    assign in_range = (32'(key_reg) < KEYS);
    assign is_mem   = in_range && (COUNT_W'(s_reg) < count_reg) && (dense_s == key_idx);

    ssmt_slot_ram u_slot_ram (
        .clk   (clk),
        .ren   (in_fire),
        .raddr (key[IDX_W-1:0]),
        .wr    (slot_wr),
        .rdata (slot_rdata)
    );

    ssmt_dense_ram u_dense_ram (
        .clk     (clk),
        .ren     (state_reg == S_LOOKUP),
        .raddr_a (slot_rdata),
        .raddr_b (last_idx),
        .wr      (dense_wr),
        .rdata_a (dense_s),
        .rdata_b (dense_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= mode_t'(mode);
            key_reg  <= key;
        end
        if (state_reg == S_LOOKUP)
        begin
            s_reg <= slot_rdata;
        end
        status_reg  <= status_next;
        present_reg <= present_next;
        mcount_reg  <= mcount_next;
        slot_reg    <= slot_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        present_next   = present_reg;
        mcount_next    = mcount_reg;
        slot_next      = slot_reg;
        slot_wr        = '0;
        dense_wr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (update_fire)
                begin
                    state_next     = in_fire ? S_LOOKUP : S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    present_next   = 1'b0;
                    slot_next      = '0;

                    if (mode_reg == MODE_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        present_next = is_mem;
                        if (is_mem)
                        begin
                            slot_next = SLOT_W'(s_reg);
                        end
                        case (mode_reg)
                            MODE_ADD:
                            begin
                                if (is_mem)
                                begin
                                    status_next = ST_DUP;
                                end
                                else if (32'(count_reg) < KEYS)
                                begin
                                    // Append at the end of the packed list
                                    slot_wr.en    = 1'b1;
                                    slot_wr.addr  = key_idx;
                                    slot_wr.data  = IDX_W'(count_reg);
                                    dense_wr.en   = 1'b1;
                                    dense_wr.addr = IDX_W'(count_reg);
                                    dense_wr.data = key_idx;
                                    slot_next     = SLOT_W'(count_reg);
                                    count_next    = count_reg + count_t'(1);
                                end
                            end
                            MODE_REMOVE:
                            begin
                                if (!is_mem)
                                begin
                                    status_next = ST_ABSENT;
                                end
                                else
                                begin
                                    count_next = count_reg - count_t'(1);
                                    // Move the last member into the freed slot
                                    if (dense_last != key_idx)
                                    begin
                                        dense_wr.en   = 1'b1;
                                        dense_wr.addr = s_reg;
                                        dense_wr.data = dense_last;
                                        slot_wr.en    = 1'b1;
                                        slot_wr.addr  = dense_last;
                                        slot_wr.data  = s_reg;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    mcount_next = count_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign present      = present_reg;
    assign member_count = mcount_reg;
    assign slot         = slot_reg;

endmodule
